// ===== rtl/core/welt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// welt_pkg: shared types and constants for the weighted edge list table
// Sizes of the table, command and status codes, the queued command record
// and the weight conversion helpers.
// ----------------------------------------------------------------------------
package welt_pkg;

    // table sizes
    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 8;
    localparam int WEIGHT_BITS  = 32;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int VTX_W    = 4;
    localparam int WT_W     = 32;
    localparam int STAT_W   = 2;
    localparam int VCOUNT_W = 5;

    // derived widths
    localparam int MEM_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int VIDX_W    = $clog2(MAX_VERTICES);
    localparam int LEN_W     = $clog2(MAX_DEGREE + 1);

    // command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // port packing
    localparam int S_TDATA_W = ((2 * VTX_W + WT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VTX_W + WT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STAT_W + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    // classified operation
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_LOOKUP,
        OP_LIST,
        OP_REJECT
    } op_t;

    // one queued command
    typedef struct packed {
        op_t                    op;
        logic [VTX_W-1:0]       src;
        logic [VTX_W-1:0]       dst;
        logic [WEIGHT_BITS-1:0] weight;
    } cmd_t;

    // one stored edge
    typedef struct packed {
        logic [VTX_W-1:0]       target;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_t;

    // keep the low WEIGHT_BITS of a sign-extended input weight
    function automatic logic [WEIGHT_BITS-1:0] to_stored(input logic signed [WT_W-1:0] w);
        logic signed [63:0] ext;
        ext = 64'(w);
        return ext[WEIGHT_BITS-1:0];
    endfunction

    // sign-extend a stored weight and report its low 32 bits
    function automatic logic [WT_W-1:0] report_weight(input logic [WEIGHT_BITS-1:0] w);
        logic signed [WEIGHT_BITS-1:0] ws;
        logic signed [63:0]            ext;
        ws  = w;
        ext = 64'(ws);
        return ext[WT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/weighted_edge_list_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_edge_list_table_top: weighted directed graph adjacency lists
// Per-vertex ordered lists of outgoing edges with insert, remove, lookup
// and list-neighbors commands.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tuser: cmd; tdata: src_vertex, dst_vertex, edge_weight
//  m_axis    out        tuser: status, found; tdata: neighbour, weight_out;
//                       tlast: last
//  cfg       in         cfg_wr_data: vertex_count, written when cfg_wr_en is high
//
//  With the sequencer idle, a reject or insert goes from the queue through
//  the decode and result states to the output register; lookup and remove
//  read and check each list entry scanned, remove then reads and writes
//  each entry it moves down; list reads and emits each edge in turn. The
//  edge memory has a registered read. Reset clears all lists at once; no
//  clearing pass. A stalled result holds the sequencer, while the two-entry
//  command queue keeps accepting beats until it fills.
// ----------------------------------------------------------------------------
module weighted_edge_list_table_top
    import welt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [VCOUNT_W-1:0]  cfg_wr_data,    // vertex_count
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // src_vertex, dst_vertex, edge_weight
    input  wire logic [CMD_W-1:0]     s_axis_tuser,   // cmd
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,   // neighbour, weight_out
    output logic [M_TUSER_W-1:0]      m_axis_tuser,   // status, found
    output logic                      m_axis_tlast
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    welt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    welt_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    welt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (head_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/welt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// welt_front: command intake
// Holds the vertex count register, checks vertex ranges and turns each
// accepted beat into a classified command for the queue.
// ----------------------------------------------------------------------------
module welt_front
    import welt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [VCOUNT_W-1:0]  cfg_wr_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [CMD_W-1:0]     s_axis_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    logic [VCOUNT_W-1:0] vcount_reg;
    logic [VTX_W-1:0]    src;
    logic [VTX_W-1:0]    dst;
    logic [WT_W-1:0]     weight_in;
    logic                src_ok;
    logic                dst_ok;

    // hold the vertex count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    // unpack the beat
    assign src       = s_axis_tdata[VTX_W-1:0];
    assign dst       = s_axis_tdata[2*VTX_W-1:VTX_W];
    assign weight_in = s_axis_tdata[2*VTX_W+WT_W-1:2*VTX_W];

    // range checks against the configured and the built-in vertex count
    assign src_ok = ({1'b0, src} < vcount_reg) && (32'(src) < MAX_VERTICES);
    assign dst_ok = ({1'b0, dst} < vcount_reg) && (32'(dst) < MAX_VERTICES);

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // classify the command
    always_comb begin
        q_cmd.src    = src;
        q_cmd.dst    = dst;
        q_cmd.weight = to_stored(signed'(weight_in));
        case (s_axis_tuser)
            CMD_INSERT: q_cmd.op = (src_ok && dst_ok) ? OP_INSERT : OP_REJECT;
            CMD_REMOVE: q_cmd.op = (src_ok && dst_ok) ? OP_REMOVE : OP_REJECT;
            CMD_LOOKUP: q_cmd.op = (src_ok && dst_ok) ? OP_LOOKUP : OP_REJECT;
            CMD_LIST:   q_cmd.op = src_ok ? OP_LIST : OP_REJECT;
            default:    q_cmd.op = OP_REJECT;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/welt_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// welt_cmd_fifo: command queue
// Short first-in first-out queue of classified commands between the
// intake and the list sequencer.
// ----------------------------------------------------------------------------
module welt_cmd_fifo
    import welt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head_cmd,
    output logic      empty
);

    cmd_t              slot_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // store the entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("command queue count above depth");

endmodule
`default_nettype wire

// ===== rtl/core/welt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// welt_back: list sequencer
// Owns the edge memory and the list lengths, walks one vertex list per
// command and drives the result channel through an output register.
// ----------------------------------------------------------------------------
module welt_back
    import welt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_empty,
    input  wire cmd_t                 q_head,
    output logic                      q_pop,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic [M_TUSER_W-1:0]      m_axis_tuser,
    output logic                      m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESP
    } state_t;

    state_t            state_reg;
    cmd_t              cur_reg;
    logic [LEN_W-1:0]  n_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  len_reg [MAX_VERTICES];

    // pending single result
    logic [STAT_W-1:0] resp_status_reg;
    logic              resp_found_reg;
    logic [VTX_W-1:0]  resp_nb_reg;
    logic [WT_W-1:0]   resp_wt_reg;

    // output register
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic              m_found_reg;
    logic [VTX_W-1:0]  m_nb_reg;
    logic [WT_W-1:0]   m_wt_reg;
    logic              m_last_reg;

    // edge memory
    edge_t             edge_mem [MEM_DEPTH];
    edge_t             rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    edge_t             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ADDR_W-1:0] base_addr;
    logic              out_free;
    logic              more_after;
    logic              at_end;
    logic              is_full;
    logic [VIDX_W-1:0] cur_vidx;

    assign cur_vidx   = VIDX_W'(cur_reg.src);
    assign base_addr  = ADDR_W'(cur_reg.src) * ADDR_W'(MAX_DEGREE);
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign at_end     = ((idx_reg + LEN_W'(1)) == n_reg);
    assign more_after = ((idx_reg + LEN_W'(1)) < n_reg);
    assign is_full    = (n_reg == LEN_W'(MAX_DEGREE));
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;

    // memory port control
    always_comb begin
        mem_re    = (state_reg == ST_SCAN_RD) || ((state_reg == ST_SHIFT_RD) && more_after);
        mem_raddr = base_addr + ADDR_W'(idx_reg) +
                    ((state_reg == ST_SHIFT_RD) ? ADDR_W'(1) : ADDR_W'(0));
        mem_we    = ((state_reg == ST_DECODE) && (cur_reg.op == OP_INSERT) && !is_full) ||
                    (state_reg == ST_SHIFT_WR);
        if (state_reg == ST_DECODE) begin
            mem_waddr        = base_addr + ADDR_W'(n_reg);
            mem_wdata.target = cur_reg.dst;
            mem_wdata.weight = cur_reg.weight;
        end else begin
            mem_waddr = base_addr + ADDR_W'(idx_reg);
            mem_wdata = rd_data_reg;
        end
    end

    // write and read the edge memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            edge_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= edge_mem[mem_raddr];
        end
    end

    // sequencer, list lengths and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                len_reg[v] <= '0;
            end
        end else begin
            // drop the result once taken
            if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        cur_reg   <= q_head;
                        n_reg     <= len_reg[VIDX_W'(q_head.src)];
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    idx_reg         <= '0;
                    resp_found_reg  <= 1'b0;
                    resp_nb_reg     <= '0;
                    resp_wt_reg     <= '0;
                    resp_status_reg <= STAT_OK;
                    state_reg       <= ST_RESP;
                    case (cur_reg.op)
                        OP_INSERT: begin
                            if (is_full) begin
                                resp_status_reg <= STAT_FULL;
                            end else begin
                                len_reg[cur_vidx] <= n_reg + LEN_W'(1);
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            if (n_reg == '0) begin
                                resp_status_reg <= STAT_NOT_FOUND;
                            end else begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        OP_LIST: begin
                            if (n_reg != '0) begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        default: begin
                            resp_status_reg <= STAT_RANGE;
                        end
                    endcase
                end
                ST_SCAN_RD: begin
                    state_reg <= ST_SCAN_CHK;
                end
                ST_SCAN_CHK: begin
                    if (cur_reg.op == OP_LIST) begin
                        // emit each edge in order
                        if (out_free) begin
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= STAT_OK;
                            m_found_reg  <= 1'b1;
                            m_nb_reg     <= rd_data_reg.target;
                            m_wt_reg     <= report_weight(rd_data_reg.weight);
                            m_last_reg   <= at_end;
                            if (at_end) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                idx_reg   <= idx_reg + LEN_W'(1);
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                    end else if (rd_data_reg.target == cur_reg.dst) begin
                        resp_status_reg <= STAT_OK;
                        resp_found_reg  <= 1'b1;
                        resp_nb_reg     <= rd_data_reg.target;
                        resp_wt_reg     <= report_weight(rd_data_reg.weight);
                        state_reg       <= (cur_reg.op == OP_REMOVE) ? ST_SHIFT_RD : ST_RESP;
                    end else if (at_end) begin
                        resp_status_reg <= STAT_NOT_FOUND;
                        state_reg       <= ST_RESP;
                    end else begin
                        idx_reg   <= idx_reg + LEN_W'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SHIFT_RD: begin
                    // close the gap one entry at a time
                    if (more_after) begin
                        state_reg <= ST_SHIFT_WR;
                    end else begin
                        len_reg[cur_vidx] <= n_reg - LEN_W'(1);
                        state_reg         <= ST_RESP;
                    end
                end
                ST_SHIFT_WR: begin
                    idx_reg   <= idx_reg + LEN_W'(1);
                    state_reg <= ST_SHIFT_RD;
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= resp_status_reg;
                        m_found_reg  <= resp_found_reg;
                        m_nb_reg     <= resp_nb_reg;
                        m_wt_reg     <= resp_wt_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - VTX_W - WT_W)'(0), m_wt_reg, m_nb_reg};
    assign m_axis_tuser  = {m_found_reg, m_status_reg};
    assign m_axis_tlast  = m_last_reg;

    a_scan_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN_CHK |-> idx_reg < n_reg)
        else $error("scan index beyond list length");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_DECODE) |-> n_reg < LEN_W'(MAX_DEGREE))
        else $error("insert written into a full list");

    a_shift_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT_WR |-> $past(mem_re))
        else $error("shift write without a preceding read");

endmodule
`default_nettype wire

// ===== tb/tb_weighted_edge_list_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_edge_list_table_top: self-checking bench for the edge list table
// Drives insert, remove, lookup and list commands over the input stream,
// predicts every result beat with a local adjacency-list model and compares
// each beat field by field. Runs a directed sequence, then random phases
// under several vertex counts, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_weighted_edge_list_table_top;
    import welt_pkg::*;

    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = 40;   // longer than any remove compaction
    localparam int IDLE_PCT     = 23;
    localparam int PHASE_ITEMS  = 50;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int QUIET_FROM   = 1500;
    localparam int QUIET_TO     = 3500;

    typedef enum logic [1:0] {
        ITEM_CMD,
        ITEM_CFG,
        ITEM_DRAIN
    } item_kind_t;

    // one entry of the stimulus backlog
    typedef struct packed {
        item_kind_t             kind;
        logic [CMD_W-1:0]       cmd;
        logic [VTX_W-1:0]       src;
        logic [VTX_W-1:0]       dst;
        logic [WT_W-1:0]        weight;
        logic [VCOUNT_W-1:0]    vcount;
    } graph_item_t;

    // one result beat
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [VTX_W-1:0]  nbr;
        logic [WT_W-1:0]   weight;
        logic              last;
    } result_beat_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [VCOUNT_W-1:0]  cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // src_vertex, dst_vertex, edge_weight
    logic [CMD_W-1:0]     s_axis_tuser  = '0;  // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // neighbour, weight_out
    logic [M_TUSER_W-1:0] m_axis_tuser;        // status, found
    logic                 m_axis_tlast;

    graph_item_t  cmd_backlog[$];
    result_beat_t expected_beats[$];
    int           mismatch_cnt = 0;
    int           beat_cnt     = 0;
    int           settle_cnt   = 0;
    int           cyc_cnt      = 0;
    logic         quiet_window;

    // adjacency-list model state
    logic [VTX_W-1:0]    adj_tgt [MAX_VERTICES][MAX_DEGREE];
    logic [WT_W-1:0]     adj_wt  [MAX_VERTICES][MAX_DEGREE];
    int                  adj_deg [MAX_VERTICES];
    logic [VCOUNT_W-1:0] model_vcount;

    weighted_edge_list_table_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
    end

    // no gaps and no stalls inside this window
    assign quiet_window = (cyc_cnt >= QUIET_FROM) && (cyc_cnt < QUIET_TO);

    task automatic flag_mismatch(input string what);
        $display("[%0t] beat %0d: %s", $time, beat_cnt, what);
        mismatch_cnt++;
    endtask

    function automatic logic vtx_ok(input logic [VTX_W-1:0] v);
        return ({1'b0, v} < model_vcount) && (int'(v) < MAX_VERTICES);
    endfunction

    function automatic result_beat_t blank_beat(input logic [STAT_W-1:0] status);
        result_beat_t b;
        b.status = status;
        b.found  = 1'b0;
        b.nbr    = '0;
        b.weight = '0;
        b.last   = 1'b1;
        return b;
    endfunction

    // update the adjacency lists and queue the beats one command produces
    task automatic apply_graph_cmd(input graph_item_t it);
        int           n;
        int           pos;
        result_beat_t b;
        if (!vtx_ok(it.src) || (it.cmd != CMD_LIST && !vtx_ok(it.dst))) begin
            expected_beats.push_back(blank_beat(STAT_RANGE));
            return;
        end
        n   = adj_deg[it.src];
        pos = -1;
        for (int i = 0; i < n; i++)
            if (pos < 0 && adj_tgt[it.src][i] == it.dst)
                pos = i;
        case (it.cmd)
            CMD_INSERT: begin
                if (n >= MAX_DEGREE) begin
                    expected_beats.push_back(blank_beat(STAT_FULL));
                end else begin
                    adj_tgt[it.src][n] = it.dst;
                    adj_wt[it.src][n]  = it.weight;
                    adj_deg[it.src]    = n + 1;
                    expected_beats.push_back(blank_beat(STAT_OK));
                end
            end
            CMD_REMOVE, CMD_LOOKUP: begin
                if (pos < 0) begin
                    expected_beats.push_back(blank_beat(STAT_NOT_FOUND));
                end else begin
                    b        = blank_beat(STAT_OK);
                    b.found  = 1'b1;
                    b.nbr    = adj_tgt[it.src][pos];
                    b.weight = adj_wt[it.src][pos];
                    expected_beats.push_back(b);
                    // close the gap, keeping order
                    if (it.cmd == CMD_REMOVE) begin
                        for (int i = pos; i + 1 < n; i++) begin
                            adj_tgt[it.src][i] = adj_tgt[it.src][i+1];
                            adj_wt[it.src][i]  = adj_wt[it.src][i+1];
                        end
                        adj_deg[it.src] = n - 1;
                    end
                end
            end
            default: begin
                if (n == 0) begin
                    expected_beats.push_back(blank_beat(STAT_OK));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        b        = blank_beat(STAT_OK);
                        b.found  = 1'b1;
                        b.nbr    = adj_tgt[it.src][i];
                        b.weight = adj_wt[it.src][i];
                        b.last   = (i + 1 == n);
                        expected_beats.push_back(b);
                    end
                end
            end
        endcase
    endtask

    function automatic graph_item_t cmd_beat(input logic [CMD_W-1:0] cmd,
                                             input int src, input int dst,
                                             input logic [WT_W-1:0] weight);
        graph_item_t it;
        it.kind   = ITEM_CMD;
        it.cmd    = cmd;
        it.src    = VTX_W'(src);
        it.dst    = VTX_W'(dst);
        it.weight = weight;
        it.vcount = '0;
        return it;
    endfunction

    function automatic graph_item_t marker(input item_kind_t kind, input int vcount);
        graph_item_t it;
        it        = cmd_beat(CMD_INSERT, 0, 0, '0);
        it.kind   = kind;
        it.vcount = VCOUNT_W'(vcount);
        return it;
    endfunction

    function automatic logic [WT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed commands on a few vertices so lists fill and hit;
    // the rest is noise over every field value
    function automatic graph_item_t rand_graph_cmd(input int vc);
        int               span;
        int               r;
        logic [CMD_W-1:0] cmd;
        span = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
        if (span == 0)
            span = 1;
        if ($urandom_range(99) < 8)
            return cmd_beat(CMD_W'($urandom_range(3)), $urandom_range(15),
                            $urandom_range(15), pick_weight());
        r = $urandom_range(99);
        if (r < 40)
            cmd = CMD_INSERT;
        else if (r < 60)
            cmd = CMD_REMOVE;
        else if (r < 80)
            cmd = CMD_LOOKUP;
        else
            cmd = CMD_LIST;
        return cmd_beat(cmd, $urandom_range(((span < 3) ? span : 3) - 1),
                        $urandom_range(((span < 4) ? span : 4) - 1), pick_weight());
    endfunction

    // stimulus, reset and end of run
    initial begin
        int phase_vc[7];

        // empty list, inserts with duplicates, hits and misses, listing
        cmd_backlog.push_back(cmd_beat(CMD_LIST,   0, 0,  32'h1234_5678));
        cmd_backlog.push_back(cmd_beat(CMD_INSERT, 0, 15, 32'h7fff_ffff));
        cmd_backlog.push_back(cmd_beat(CMD_INSERT, 0, 3,  32'h8000_0000));
        cmd_backlog.push_back(cmd_beat(CMD_INSERT, 0, 3,  32'hffff_ffff));
        cmd_backlog.push_back(cmd_beat(CMD_INSERT, 0, 0,  32'h0000_0000));
        cmd_backlog.push_back(cmd_beat(CMD_LOOKUP, 0, 3,  32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_LOOKUP, 0, 7,  32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_LIST,   0, 9,  32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_REMOVE, 0, 3,  32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_REMOVE, 0, 9,  32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_LIST,   0, 0,  32'h0));
        // fill vertex 15 to the degree bound, then overflow it
        for (int i = 0; i < MAX_DEGREE + 1; i++)
            cmd_backlog.push_back(cmd_beat(CMD_INSERT, 15, 15 - i, $urandom));
        cmd_backlog.push_back(cmd_beat(CMD_LIST, 15, 0, 32'h0));
        // zero vertex count rejects everything
        cmd_backlog.push_back(marker(ITEM_CFG, 0));
        cmd_backlog.push_back(cmd_beat(CMD_INSERT, 0, 0, 32'h5));
        cmd_backlog.push_back(cmd_beat(CMD_LIST,   0, 0, 32'h0));
        // out of range on source, on target, and list checking source only
        cmd_backlog.push_back(marker(ITEM_CFG, 4));
        cmd_backlog.push_back(cmd_beat(CMD_INSERT, 5, 0, 32'h9));
        cmd_backlog.push_back(cmd_beat(CMD_LOOKUP, 0, 4, 32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_LIST,   0, 12, 32'h0));
        cmd_backlog.push_back(cmd_beat(CMD_LIST,   4, 0, 32'h0));

        // random phases, extremes of the vertex count among them
        phase_vc = '{16, 1, 31, 17, 3, $urandom_range(1, 16), 2};
        foreach (phase_vc[p]) begin
            cmd_backlog.push_back(marker(ITEM_CFG, phase_vc[p]));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2 && (p % 3) == 0)
                    cmd_backlog.push_back(marker(ITEM_DRAIN, 0));
                cmd_backlog.push_back(rand_graph_cmd(phase_vc[p]));
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("weighted_edge_list_table_top: match");
        else
            $display("weighted_edge_list_table_top: mismatch");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("weighted_edge_list_table_top: mismatch");
        $finish;
    end

    // driver: feed the input stream and the register from the backlog
    always @(posedge aclk) begin : drv
        logic        nxt_valid;
        logic        nxt_wr;
        logic        drained;
        graph_item_t head;
        nxt_valid = s_axis_tvalid && !s_axis_tready;
        nxt_wr    = 1'b0;
        if (!aresetn) begin
            nxt_valid  = 1'b0;
            settle_cnt = 0;
        end else begin
            drained = !s_axis_tvalid && expected_beats.size() == 0;
            if (drained)
                settle_cnt++;
            else
                settle_cnt = 0;
            if (!nxt_valid && cmd_backlog.size() != 0) begin
                head = cmd_backlog[0];
                case (head.kind)
                    ITEM_CMD: begin
                        if (quiet_window || $urandom_range(99) >= IDLE_PCT) begin
                            nxt_valid    = 1'b1;
                            s_axis_tdata <= {head.weight, head.dst, head.src};
                            s_axis_tuser <= head.cmd;
                            cmd_backlog.delete(0);
                        end
                    end
                    ITEM_CFG: begin
                        // write only once the block has gone quiet
                        if (drained && settle_cnt >= SETTLE) begin
                            nxt_wr      = 1'b1;
                            cfg_wr_data <= head.vcount;
                            cmd_backlog.delete(0);
                        end
                    end
                    default: begin
                        // hold off until every expected beat has come
                        if (drained)
                            cmd_backlog.delete(0);
                    end
                endcase
            end
        end
        s_axis_tvalid <= nxt_valid;
        cfg_wr_en     <= nxt_wr;
    end

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge aclk) begin : mon
        graph_item_t  acc;
        result_beat_t got;
        result_beat_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            model_vcount  = VCOUNT_RESET;
            foreach (adj_deg[v])
                adj_deg[v] = 0;
        end else begin
            m_axis_tready <= quiet_window || ($urandom_range(99) >= IDLE_PCT);
            if (cfg_wr_en)
                model_vcount = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                acc        = cmd_beat(s_axis_tuser, 0, 0, '0);
                acc.src    = s_axis_tdata[VTX_W-1:0];
                acc.dst    = s_axis_tdata[2*VTX_W-1:VTX_W];
                acc.weight = s_axis_tdata[2*VTX_W+WT_W-1:2*VTX_W];
                apply_graph_cmd(acc);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser[STAT_W-1:0];
                got.found  = m_axis_tuser[STAT_W];
                got.nbr    = m_axis_tdata[VTX_W-1:0];
                got.weight = m_axis_tdata[VTX_W+WT_W-1:VTX_W];
                got.last   = m_axis_tlast;
                if (expected_beats.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_beats.pop_front();
                    if (got.status != want.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                got.status, want.status));
                    if (got.found != want.found)
                        flag_mismatch($sformatf("found %0d, want %0d",
                                                got.found, want.found));
                    if (got.nbr != want.nbr)
                        flag_mismatch($sformatf("neighbour %0d, want %0d",
                                                got.nbr, want.nbr));
                    if (got.weight != want.weight)
                        flag_mismatch($sformatf("weight %h, want %h",
                                                got.weight, want.weight));
                    if (got.last != want.last)
                        flag_mismatch($sformatf("last %0d, want %0d",
                                                got.last, want.last));
                end
                beat_cnt++;
            end
        end
    end

endmodule
